/* hw/rtl/crpg_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// crpg_pkg
// Shared types, widths and codes of the channel ramp and pulse generator.
// ============================================================================
package crpg_pkg;

    // field widths of the item, result and config ports
    localparam int OP_W    = 2;
    localparam int CHAN_W  = 10;
    localparam int TIME_W  = 16;
    localparam int LEVEL_W = 8;
    localparam int REPS_W  = 16;
    localparam int TPM_W   = 7;

    // slot storage widths
    localparam int REM_W = 17;
    localparam int PER_W = 24;

    // ticks_per_ms after reset
    localparam logic [TPM_W-1:0] TPM_RESET = 7'd10;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_RAMP  = 2'd1;
    localparam logic [OP_W-1:0] OP_PULSE = 2'd2;
    localparam logic [OP_W-1:0] OP_SET   = 2'd3;

    // slot waveform kind
    typedef enum logic [1:0] {
        KIND_INACTIVE = 2'd0,
        KIND_RAMP     = 2'd1,
        KIND_PULSE    = 2'd2
    } kind_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_RAMP,
        ST_DIV,
        ST_LOAD
    } state_t;

    // request to the ramp period divider
    typedef struct packed {
        logic               start;
        logic [TIME_W-1:0]  dividend;
        logic [LEVEL_W-1:0] divisor;
    } div_req_t;

    // answer of the ramp period divider
    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* hw/rtl/crpg_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// crpg_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module crpg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/crpg_div.sv */
`timescale 1ns / 1ps
// ============================================================================
// crpg_div
// Restoring divider, one quotient bit per cycle, for ramp step periods.
// ============================================================================
module crpg_div (
    input  logic                clk,
    input  logic                rst_n,
    input  crpg_pkg::div_req_t  req,
    output crpg_pkg::div_rsp_t  rsp
);

    localparam int TW  = crpg_pkg::TIME_W;
    localparam int LW  = crpg_pkg::LEVEL_W;
    localparam int CNW = $clog2(TW + 1);

    logic [CNW-1:0] cnt_reg;
    logic [CNW-1:0] cnt_next;
    logic           done_reg;
    logic           done_next;
    logic [LW-1:0]  rem_reg;
    logic [LW-1:0]  rem_next;
    logic [TW-1:0]  quo_reg;
    logic [TW-1:0]  quo_next;
    logic [LW-1:0]  dvs_reg;
    logic [LW:0]    trial;
    logic           fits;

    // one trial subtract per cycle
    assign trial = {rem_reg, quo_reg[TW-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            cnt_next = CNW'(TW);
            rem_next = '0;
            quo_next = req.dividend;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNW'(1);
            done_next = (cnt_reg == CNW'(1));
            rem_next  = fits ? LW'(trial - {1'b0, dvs_reg}) : trial[LW-1:0];
            quo_next  = {quo_reg[TW-2:0], fits};
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start)
        begin
            dvs_reg <= req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* hw/rtl/channel_ramp_pulse_generator.sv */
`timescale 1ns / 1ps
// ============================================================================
// channel_ramp_pulse_generator
// Channel level store with ramp and pulse waveform slots driven by ticks.
// ============================================================================
//
//  port group   direction  handshake                  payload
//  -----------  ---------  -------------------------  ---------------------------
//  item         in         start high, busy low       op channel time_ms
//                                                     start_level stop_level repeats
//  result       out        out_strobe, one cycle      write_valid out_channel
//                                                     out_level status last
//  config       in         cfg_we                     cfg_wdata (ticks_per_ms)
//
//  After reset the level store is cleared, one channel a cycle, with busy high.
//  A set item or an item that writes nothing is answered from idle; a pulse
//  start passes through the load state, a ramp start through the divider and
//  then the load state. A tick walks the slots up to the highest due slot,
//  with a ramp state for each due ramp (level store read latency).
//  Each result shows for one cycle, in the cycle after the work that made it.
//
module channel_ramp_pulse_generator #(
    parameter int NUM_SLOTS    = 10,
    parameter int NUM_CHANNELS = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [crpg_pkg::OP_W-1:0]     op,
    input  logic [crpg_pkg::CHAN_W-1:0]   channel,
    input  logic [crpg_pkg::TIME_W-1:0]   time_ms,
    input  logic [crpg_pkg::LEVEL_W-1:0]  start_level,
    input  logic [crpg_pkg::LEVEL_W-1:0]  stop_level,
    input  logic [crpg_pkg::REPS_W-1:0]   repeats,
    input  logic                          cfg_we,
    input  logic [crpg_pkg::TPM_W-1:0]    cfg_wdata,
    output logic                          out_strobe,
    output logic                          write_valid,
    output logic [crpg_pkg::CHAN_W-1:0]   out_channel,
    output logic [crpg_pkg::LEVEL_W-1:0]  out_level,
    output logic                          status,
    output logic                          last
);

    localparam int CHW    = crpg_pkg::CHAN_W;
    localparam int LW     = crpg_pkg::LEVEL_W;
    localparam int TW     = crpg_pkg::TIME_W;
    localparam int RW     = crpg_pkg::REPS_W;
    localparam int TPW    = crpg_pkg::TPM_W;
    localparam int REMW   = crpg_pkg::REM_W;
    localparam int PERW   = crpg_pkg::PER_W;
    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // sequencer and item registers
    crpg_pkg::state_t state_reg;
    crpg_pkg::state_t state_next;
    logic [CH_W-1:0]      clr_cnt_reg;
    logic [CH_W-1:0]      clr_cnt_next;
    logic [SLOT_W-1:0]    idx_reg;
    logic [SLOT_W-1:0]    idx_next;
    logic [NUM_SLOTS-1:0] mask_reg;
    logic [NUM_SLOTS-1:0] mask_next;
    logic [TW-1:0]        q_reg;
    logic [TW-1:0]        q_next;
    logic [TPW-1:0]       ticks_reg;
    logic [CH_W-1:0]      chan_idx_reg;
    logic [LW-1:0]        lvl_a_reg;
    logic [LW-1:0]        lvl_b_reg;
    logic [RW-1:0]        reps_reg;
    logic                 is_ramp_reg;
    logic [SLOT_W-1:0]    free_reg;

    // slot table
    crpg_pkg::kind_t kind_reg [NUM_SLOTS];
    logic [CH_W-1:0]  sch_reg     [NUM_SLOTS];
    logic [LW-1:0]    sstart_reg  [NUM_SLOTS];
    logic [LW-1:0]    sstop_reg   [NUM_SLOTS];
    logic [PERW-1:0]  period_reg  [NUM_SLOTS];
    logic [PERW-1:0]  wait_reg    [NUM_SLOTS];
    logic             rising_reg  [NUM_SLOTS];
    logic [REMW-1:0]  rem_reg     [NUM_SLOTS];
    logic             at_stop_reg [NUM_SLOTS];

    // result registers
    logic            strobe_reg;
    logic            strobe_next;
    logic            wv_reg;
    logic            wv_next;
    logic [CHW-1:0]  och_reg;
    logic [CHW-1:0]  och_next;
    logic [LW-1:0]   olvl_reg;
    logic [LW-1:0]   olvl_next;
    logic            ostat_reg;
    logic            ostat_next;
    logic            olast_reg;
    logic            olast_next;

    // control strobes from the sequencer
    logic tick_dec;
    logic slot_step;
    logic slot_load;

    // level store port
    logic            ram_we;
    logic [CH_W-1:0] ram_waddr;
    logic [LW-1:0]   ram_wdata;
    logic [CH_W-1:0] ram_raddr;
    logic [LW-1:0]   ram_rdata;

    // divider
    crpg_pkg::div_req_t div_req;
    crpg_pkg::div_rsp_t div_rsp;

    // item decode
    logic                 accept;
    logic                 chan_ok;
    logic [CHW-1:0]       chan_m1;
    logic                 free_found;
    logic [SLOT_W-1:0]    free_idx;
    logic [NUM_SLOTS-1:0] due_mask;
    logic [LW-1:0]        dist_raw;
    logic [LW-1:0]        lvl_dist;

    // current slot during a tick walk
    logic [NUM_SLOTS-1:0] idx_onehot;
    logic                 last_here;
    crpg_pkg::kind_t      cur_kind;
    logic [CH_W-1:0]      cur_ch;
    logic [LW-1:0]        cur_start;
    logic [LW-1:0]        cur_stop;
    logic [REMW-1:0]      cur_rem;
    logic [LW-1:0]        stepped;
    logic                 hit_stop;
    logic [LW-1:0]        ramp_v;
    logic [LW-1:0]        pulse_v;

    // period product
    logic [TW+TPW-1:0] prod_raw;
    logic [PERW-1:0]   period_new;

    assign accept  = start && (state_reg == crpg_pkg::ST_IDLE);
    assign chan_ok = (channel != '0) && (channel <= CHW'(NUM_CHANNELS));
    assign chan_m1 = channel - CHW'(1);

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (kind_reg[i] == crpg_pkg::KIND_INACTIVE)
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // slots that act on this tick
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            due_mask[i] = (kind_reg[i] != crpg_pkg::KIND_INACTIVE) && (wait_reg[i] == '0);
        end
    end

    // level distance of a ramp, zero taken as one
    assign dist_raw = (stop_level >= start_level) ? (stop_level - start_level)
                                                  : (start_level - stop_level);
    assign lvl_dist = (dist_raw == '0) ? LW'(1) : dist_raw;

    // walk position
    assign idx_onehot = NUM_SLOTS'(1) << idx_reg;
    assign last_here  = ((mask_reg & ~idx_onehot) == '0);
    assign cur_kind   = kind_reg[idx_reg];
    assign cur_ch     = sch_reg[idx_reg];
    assign cur_start  = sstart_reg[idx_reg];
    assign cur_stop   = sstop_reg[idx_reg];
    assign cur_rem    = rem_reg[idx_reg];

    // ramp step and pulse level
    assign stepped  = rising_reg[idx_reg] ? (ram_rdata + LW'(1)) : (ram_rdata - LW'(1));
    assign hit_stop = (stepped == cur_stop);
    assign ramp_v   = (hit_stop && (cur_rem != '0)) ? cur_start : stepped;
    assign pulse_v  = at_stop_reg[idx_reg] ? cur_start : cur_stop;

    // period from quotient or time
    assign prod_raw   = q_reg * ticks_reg;
    assign period_new = PERW'(prod_raw);

    assign ram_raddr = cur_ch;

    // divider request
    assign div_req.start    = accept && (op == crpg_pkg::OP_RAMP) && chan_ok && free_found;
    assign div_req.dividend = time_ms;
    assign div_req.divisor  = lvl_dist;

    // sequencer: next state, level store writes, results
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        idx_next     = idx_reg;
        mask_next    = mask_reg;
        q_next       = q_reg;
        tick_dec     = 1'b0;
        slot_step    = 1'b0;
        slot_load    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = cur_ch;
        ram_wdata    = ramp_v;
        strobe_next  = 1'b0;
        wv_next      = wv_reg;
        och_next     = och_reg;
        olvl_next    = olvl_reg;
        ostat_next   = ostat_reg;
        olast_next   = olast_reg;
        unique case (state_reg)
            crpg_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + CH_W'(1);
                if (clr_cnt_reg == CH_W'(NUM_CHANNELS - 1))
                begin
                    state_next = crpg_pkg::ST_IDLE;
                end
            end
            crpg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    strobe_next = 1'b1;
                    wv_next     = 1'b0;
                    och_next    = '0;
                    olvl_next   = '0;
                    ostat_next  = 1'b0;
                    olast_next  = 1'b1;
                    priority if (op == crpg_pkg::OP_TICK)
                    begin
                        tick_dec  = 1'b1;
                        mask_next = due_mask;
                        idx_next  = '0;
                        if (due_mask != '0)
                        begin
                            strobe_next = 1'b0;
                            state_next  = crpg_pkg::ST_WALK;
                        end
                    end
                    else if (!chan_ok)
                    begin
                        // bad channel: quiet result
                    end
                    else if (op == crpg_pkg::OP_SET)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = CH_W'(chan_m1);
                        ram_wdata = start_level;
                        wv_next   = 1'b1;
                        och_next  = channel;
                        olvl_next = start_level;
                    end
                    else if (!free_found)
                    begin
                        ostat_next = 1'b1;
                    end
                    else
                    begin
                        strobe_next = 1'b0;
                        if (op == crpg_pkg::OP_RAMP)
                        begin
                            state_next = crpg_pkg::ST_DIV;
                        end
                        else
                        begin
                            q_next     = time_ms;
                            state_next = crpg_pkg::ST_LOAD;
                        end
                    end
                end
            end
            crpg_pkg::ST_WALK:
            begin
                if (!mask_reg[idx_reg])
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
                else if (cur_kind == crpg_pkg::KIND_RAMP)
                begin
                    state_next = crpg_pkg::ST_RAMP;
                end
                else
                begin
                    ram_we      = 1'b1;
                    ram_wdata   = pulse_v;
                    slot_step   = 1'b1;
                    strobe_next = 1'b1;
                    wv_next     = 1'b1;
                    och_next    = CHW'(cur_ch) + CHW'(1);
                    olvl_next   = pulse_v;
                    ostat_next  = 1'b0;
                    olast_next  = last_here;
                    mask_next   = mask_reg & ~idx_onehot;
                    idx_next    = idx_reg + SLOT_W'(1);
                    if (last_here)
                    begin
                        state_next = crpg_pkg::ST_IDLE;
                    end
                end
            end
            crpg_pkg::ST_RAMP:
            begin
                ram_we      = 1'b1;
                ram_wdata   = ramp_v;
                slot_step   = 1'b1;
                strobe_next = 1'b1;
                wv_next     = 1'b1;
                och_next    = CHW'(cur_ch) + CHW'(1);
                olvl_next   = ramp_v;
                ostat_next  = 1'b0;
                olast_next  = last_here;
                mask_next   = mask_reg & ~idx_onehot;
                idx_next    = idx_reg + SLOT_W'(1);
                state_next  = last_here ? crpg_pkg::ST_IDLE : crpg_pkg::ST_WALK;
            end
            crpg_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    q_next     = div_rsp.quotient;
                    state_next = crpg_pkg::ST_LOAD;
                end
            end
            crpg_pkg::ST_LOAD:
            begin
                slot_load   = 1'b1;
                ram_we      = 1'b1;
                ram_waddr   = chan_idx_reg;
                ram_wdata   = lvl_a_reg;
                strobe_next = 1'b1;
                wv_next     = 1'b1;
                och_next    = CHW'(chan_idx_reg) + CHW'(1);
                olvl_next   = lvl_a_reg;
                ostat_next  = 1'b0;
                olast_next  = 1'b1;
                state_next  = crpg_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = crpg_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer state, config and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= crpg_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            idx_reg     <= '0;
            mask_reg    <= '0;
            ticks_reg   <= crpg_pkg::TPM_RESET;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            idx_reg     <= idx_next;
            mask_reg    <= mask_next;
            strobe_reg  <= strobe_next;
            if (cfg_we)
            begin
                ticks_reg <= cfg_wdata;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        q_reg     <= q_next;
        wv_reg    <= wv_next;
        och_reg   <= och_next;
        olvl_reg  <= olvl_next;
        ostat_reg <= ostat_next;
        olast_reg <= olast_next;
        if (accept)
        begin
            chan_idx_reg <= CH_W'(chan_m1);
            lvl_a_reg    <= start_level;
            lvl_b_reg    <= stop_level;
            reps_reg     <= repeats;
            is_ramp_reg  <= (op == crpg_pkg::OP_RAMP);
            free_reg     <= free_idx;
        end
    end

    // slot table updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                kind_reg[i]    <= crpg_pkg::KIND_INACTIVE;
                sch_reg[i]     <= '0;
                sstart_reg[i]  <= '0;
                sstop_reg[i]   <= '0;
                period_reg[i]  <= '0;
                wait_reg[i]    <= '0;
                rising_reg[i]  <= 1'b1;
                rem_reg[i]     <= REMW'(1);
                at_stop_reg[i] <= 1'b0;
            end
        end
        else
        begin
            // count down every waiting slot at once
            if (tick_dec)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if ((kind_reg[i] != crpg_pkg::KIND_INACTIVE) && (wait_reg[i] != '0))
                    begin
                        wait_reg[i] <= wait_reg[i] - PERW'(1);
                    end
                end
            end
            // due slot acts
            if (slot_step)
            begin
                if (cur_kind == crpg_pkg::KIND_RAMP)
                begin
                    wait_reg[idx_reg] <= period_reg[idx_reg];
                    if (hit_stop)
                    begin
                        if (cur_rem == '0)
                        begin
                            kind_reg[idx_reg] <= crpg_pkg::KIND_INACTIVE;
                        end
                        else
                        begin
                            rem_reg[idx_reg] <= cur_rem - REMW'(1);
                        end
                    end
                end
                else if (cur_rem == '0)
                begin
                    kind_reg[idx_reg] <= crpg_pkg::KIND_INACTIVE;
                end
                else
                begin
                    wait_reg[idx_reg]    <= period_reg[idx_reg];
                    at_stop_reg[idx_reg] <= !at_stop_reg[idx_reg];
                    rem_reg[idx_reg]     <= cur_rem - REMW'(1);
                end
            end
            // claim a free slot
            if (slot_load)
            begin
                sch_reg[free_reg]    <= chan_idx_reg;
                sstart_reg[free_reg] <= lvl_a_reg;
                sstop_reg[free_reg]  <= lvl_b_reg;
                period_reg[free_reg] <= period_new;
                wait_reg[free_reg]   <= period_new;
                if (is_ramp_reg)
                begin
                    kind_reg[free_reg]   <= crpg_pkg::KIND_RAMP;
                    rem_reg[free_reg]    <= REMW'(reps_reg) - REMW'(1);
                    rising_reg[free_reg] <= (lvl_a_reg <= lvl_b_reg);
                end
                else
                begin
                    kind_reg[free_reg]    <= crpg_pkg::KIND_PULSE;
                    rem_reg[free_reg]     <= {reps_reg - RW'(1), 1'b0};
                    at_stop_reg[free_reg] <= 1'b0;
                end
            end
        end
    end

    // channel level store
    crpg_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_CHANNELS)
    ) u_levels (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // divider for ramp periods
    crpg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign busy        = (state_reg != crpg_pkg::ST_IDLE);
    assign out_strobe  = strobe_reg;
    assign write_valid = wv_reg;
    assign out_channel = och_reg;
    assign out_level   = olvl_reg;
    assign status      = ostat_reg;
    assign last        = olast_reg;

endmodule

/* hw/rtl/crpg_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// crpg_checker
// Port level checks of the channel ramp and pulse generator.
// ============================================================================
module crpg_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          out_strobe,
    input logic                          write_valid,
    input logic [crpg_pkg::CHAN_W-1:0]   out_channel,
    input logic [crpg_pkg::LEVEL_W-1:0]  out_level,
    input logic                          status,
    input logic                          last
);

    // an accepted item either answers at once or keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || out_strobe))
    else $error("accepted item neither answered nor worked on");

    // more results of the same item follow while busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_strobe && !last) |-> busy)
    else $error("non-final result while idle");

    // a no-slot result stands alone and writes nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_strobe && status) |-> (last && !write_valid))
    else $error("no-slot result malformed");

    // a result without a write carries no channel and no level
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_strobe && !write_valid) |-> ((out_channel == '0) && (out_level == '0)))
    else $error("non-write result carries data");

    // a level write names a real channel
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_strobe && write_valid) |-> ((out_channel != '0) && !status))
    else $error("level write with channel zero or bad status");

endmodule

bind channel_ramp_pulse_generator crpg_checker u_crpg_checker (.*);
